@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SFHQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFHQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sfhq_pkg.sv @@
package sfhq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = ADDR_W + 2;   // holds 2*node+2
    localparam int REM_W       = 7;

    localparam int TAG_W  = 16;
    localparam int AGE_W  = 7;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    localparam logic [AGE_W-1:0] SENIOR_AGE_RESET = AGE_W'(60);

    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [AGE_W-1:0]  age;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } entry_t;

    // a ranks strictly before b: seniority first, then earlier arrival
    function automatic logic ranks_before(input entry_t a, input entry_t b,
                                          input logic [AGE_W-1:0] senior);
        logic sa;
        logic sb;
        sa = (a.age >= senior);
        sb = (b.age >= senior);
        if (sa != sb)
            return sa;
        return {a.hour, a.minute, a.second} < {b.hour, b.minute, b.second};
    endfunction

endpackage

@@ rtl/core/senior_first_heap_queue.sv @@
// Senior-first priority queue, held as a binary heap in a 64-entry memory
// with separate read and write addresses (one write and one registered read
// per cycle). kind 0 loads an entry (ST_FULL if full) and posts its result to
// the output register from the accept cycle. kind 1 pops the best entry:
// senior entries (age >= senior_age) first, then earliest hour:minute:second
// (ST_EMPTY if empty). The first pop after loads builds the heap bottom-up,
// sifting down each of the n/2 inner nodes from the last to the root. A pop
// fetches root and last entry, then per level the entry moves down reads the
// left child, compares it while reading the right one, compares that and
// moves the winning child up; it ends by parking the sifted entry and posting
// the result. All sifting uses ranks_before and the heap memory, stepped by
// the sequencer below; in_ready is low while it runs and while an untaken
// result blocks the output register. senior_age may be rewritten through
// cfg_we/cfg_wdata at any idle moment; it takes effect on the next compare.
module senior_first_heap_queue
    import sfhq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [AGE_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [TAG_W-1:0]  tag,
    input  logic [AGE_W-1:0]  age,
    input  logic [HOUR_W-1:0] hour,
    input  logic [MIN_W-1:0]  minute,
    input  logic [SEC_W-1:0]  second,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [TAG_W-1:0]  out_tag,
    output logic [AGE_W-1:0]  out_age,
    output logic [HOUR_W-1:0] out_hour,
    output logic [MIN_W-1:0]  out_minute,
    output logic [SEC_W-1:0]  out_second,
    output logic [REM_W-1:0]  remaining
);

`include "assert_macros.svh"

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_POP0 = 4'd1;   // read root
    localparam logic [3:0] S_POP1 = 4'd2;   // capture root, read last
    localparam logic [3:0] S_POP2 = 4'd3;   // capture last, start sift
    localparam logic [3:0] S_BLD0 = 4'd4;   // read build node
    localparam logic [3:0] S_BLD1 = 4'd5;   // capture build node
    localparam logic [3:0] S_RDL  = 4'd6;   // read left child
    localparam logic [3:0] S_RDR  = 4'd7;   // compare left, read right
    localparam logic [3:0] S_CMP  = 4'd8;   // compare right, move child up
    localparam logic [3:0] S_WB   = 4'd9;   // park sifted entry
    localparam logic [3:0] S_OUT  = 4'd10;  // post pop result

    // heap memory
    entry_t mem [QUEUE_DEPTH];
    entry_t rd_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              built_reg, built_next;
    logic [AGE_W-1:0]  senior_reg, senior_next;
    logic              out_valid_reg, out_valid_next;
    logic              ctx_build_reg, ctx_build_next;
    logic              bsel_reg, bsel_next;

    // datapath registers
    logic [ADDR_W-1:0] node_reg, node_next;
    logic [ADDR_W-1:0] bidx_reg, bidx_next;
    entry_t            sift_reg, sift_next;
    entry_t            best_reg, best_next;
    entry_t            got_reg, got_next;
    logic [1:0]        status_reg, status_next;
    entry_t            res_reg, res_next;
    logic [REM_W-1:0]  rem_reg, rem_next;

    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
    logic [IDX_W-1:0]  count_ext;
    logic              out_free;
    logic              in_xfer;
    entry_t            in_entry;
    entry_t            zero_entry;

    assign left_idx   = IDX_W'({node_reg, 1'b1});
    assign right_idx  = left_idx + IDX_W'(1);
    assign count_ext  = IDX_W'(count_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE) && out_free;
    assign in_xfer    = in_valid && in_ready;
    assign in_entry   = '{tag: tag, age: age, hour: hour, minute: minute, second: second};
    assign zero_entry = '0;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        built_next     = built_reg;
        senior_next    = cfg_we ? cfg_wdata : senior_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctx_build_next = ctx_build_reg;
        bsel_next      = bsel_reg;
        node_next      = node_reg;
        bidx_next      = bidx_reg;
        sift_next      = sift_reg;
        best_next      = best_reg;
        got_next       = got_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        rem_next       = rem_reg;
        rd_addr        = node_reg;
        wr_en          = 1'b0;
        wr_addr        = node_reg;
        wr_data        = sift_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!kind)
                    begin
                        // load answers at once
                        out_valid_next = 1'b1;
                        res_next       = zero_entry;
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            status_next = ST_FULL;
                            rem_next    = REM_W'(count_reg);
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = ADDR_W'(count_reg);
                            wr_data     = in_entry;
                            count_next  = count_reg + CNT_W'(1);
                            built_next  = 1'b0;
                            status_next = ST_LOADED;
                            rem_next    = REM_W'(count_reg + CNT_W'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_EMPTY;
                        res_next       = zero_entry;
                        rem_next       = '0;
                    end
                    else if (!built_reg && (count_reg >= CNT_W'(2)))
                    begin
                        bidx_next      = ADDR_W'((count_reg - CNT_W'(2)) >> 1);
                        ctx_build_next = 1'b1;
                        state_next     = S_BLD0;
                    end
                    else
                    begin
                        built_next = 1'b1;
                        state_next = S_POP0;
                    end
                end
            end
            S_POP0:
            begin
                rd_addr    = '0;
                state_next = S_POP1;
            end
            S_POP1:
            begin
                got_next   = rd_reg;
                rd_addr    = ADDR_W'(count_reg - CNT_W'(1));
                state_next = S_POP2;
            end
            S_POP2:
            begin
                sift_next      = rd_reg;
                count_next     = count_reg - CNT_W'(1);
                node_next      = '0;
                ctx_build_next = 1'b0;
                state_next     = (count_reg == CNT_W'(1)) ? S_OUT : S_RDL;
            end
            S_BLD0:
            begin
                rd_addr    = bidx_reg;
                state_next = S_BLD1;
            end
            S_BLD1:
            begin
                sift_next  = rd_reg;
                node_next  = bidx_reg;
                state_next = S_RDL;
            end
            S_RDL:
            begin
                rd_addr    = left_idx[ADDR_W-1:0];
                state_next = (left_idx < count_ext) ? S_RDR : S_WB;
            end
            S_RDR:
            begin
                // rd_reg holds the left child
                bsel_next  = ranks_before(rd_reg, sift_reg, senior_reg);
                best_next  = bsel_next ? rd_reg : sift_reg;
                rd_addr    = right_idx[ADDR_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // rd_reg holds the right child when it exists
                if ((right_idx < count_ext) && ranks_before(rd_reg, best_reg, senior_reg))
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_reg;
                    node_next  = right_idx[ADDR_W-1:0];
                    state_next = S_RDL;
                end
                else if (bsel_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = best_reg;
                    node_next  = left_idx[ADDR_W-1:0];
                    state_next = S_RDL;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                wr_en   = 1'b1;
                wr_data = sift_reg;
                if (!ctx_build_reg)
                    state_next = S_OUT;
                else if (bidx_reg == '0)
                begin
                    built_next = 1'b1;
                    state_next = S_POP0;
                end
                else
                begin
                    bidx_next  = bidx_reg - ADDR_W'(1);
                    state_next = S_BLD0;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_POPPED;
                    res_next       = got_reg;
                    rem_next       = REM_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            built_reg     <= 1'b1;
            senior_reg    <= SENIOR_AGE_RESET;
            out_valid_reg <= 1'b0;
            ctx_build_reg <= 1'b0;
            bsel_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            built_reg     <= built_next;
            senior_reg    <= senior_next;
            out_valid_reg <= out_valid_next;
            ctx_build_reg <= ctx_build_next;
            bsel_reg      <= bsel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        bidx_reg   <= bidx_next;
        sift_reg   <= sift_next;
        best_reg   <= best_next;
        got_reg    <= got_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        rem_reg    <= rem_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_tag    = res_reg.tag;
    assign out_age    = res_reg.age;
    assign out_hour   = res_reg.hour;
    assign out_minute = res_reg.minute;
    assign out_second = res_reg.second;
    assign remaining  = rem_reg;

    `SFHQ_ASSERT(a_count_bound, clk, rst_n, (count_reg <= CNT_W'(QUEUE_DEPTH)), "entry count beyond depth")
    `SFHQ_ASSERT(a_load_count, clk, rst_n, (in_xfer && !kind && (count_reg != CNT_W'(QUEUE_DEPTH))) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "load did not bump count")
    `SFHQ_ASSERT(a_idle_remaining, clk, rst_n, (out_valid_reg && (state_reg == S_IDLE)) |-> (rem_reg == REM_W'(count_reg)), "remaining out of step with count")
    `SFHQ_ASSERT(a_build_unbuilt, clk, rst_n, ((state_reg == S_BLD0) || (state_reg == S_BLD1)) |-> !built_reg, "build pass on built heap")

endmodule
